// ===== src/atsa_pkg.sv =====
package atsa_pkg;

    // fixed field widths
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 7;
    localparam int POS_W   = 16;
    localparam int IN_W    = 40;   // span_x, span_y, span_count, padded to bytes
    localparam int OUT_W   = 32;   // texel_x, texel_y
    localparam int MUL_B_W = 18;   // 2*pos+1 as a signed operand
    localparam int PROD_W  = CFG_W + MUL_B_W;
    localparam int ACC_W   = 52;   // doubled-unit source coordinate

    // register indexes
    localparam logic [IDX_W-1:0] CFG_INV_XX    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_INV_XY    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_INV_XT    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_INV_YX    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_INV_YY    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_INV_YT    = 3'd5;
    localparam logic [IDX_W-1:0] CFG_TILE_MODE = 3'd6;
    localparam logic [IDX_W-1:0] CFG_TEX_SIZE  = 3'd7;

    // tile modes (unused code acts as clamp)
    localparam logic [1:0] TILE_CLAMP  = 2'd0;
    localparam logic [1:0] TILE_REPEAT = 2'd1;
    localparam logic [1:0] TILE_MIRROR = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MOD_GO,
        S_MOD_WAIT,
        S_EMIT
    } t_state;

endpackage

// ===== src/atsa_mod.sv =====
// Floor modulo, one dividend bit per cycle (restoring).
// Result is always in [0, divisor).
module atsa_mod
    import atsa_pkg::*;
#(
    parameter int DW = 35,
    parameter int PW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_value,    // signed
    input  logic [PW-1:0] i_divisor,  // nonzero
    output logic          o_done,
    output logic [PW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic          r_neg,  n_neg;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [DW-1:0] r_mag,  n_mag;
    logic [PW-1:0] r_rem,  n_rem;
    logic [PW-1:0] r_div,  n_div;
    logic [PW:0]   w_sh;
    logic [PW:0]   w_sub;

    assign w_sh  = {r_rem, r_mag[DW-1]};
    assign w_sub = w_sh - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_mag  = r_mag;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_neg  = i_value[DW-1];
            n_mag  = i_value[DW-1] ? (~i_value + DW'(1)) : i_value;
            n_cnt  = CW'(DW);
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_rem = (w_sh >= {1'b0, r_div}) ? w_sub[PW-1:0] : w_sh[PW-1:0];
                n_mag = r_mag << 1;
                n_cnt = r_cnt - CW'(1);
            end else begin
                // last step: finish and, for a negative dividend, fold remainder back into range
                n_busy = 1'b0;
                n_done = 1'b1;
                if (r_neg && (r_rem != '0)) begin
                    n_rem = r_div - r_rem;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_mag <= n_mag;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== src/affine_texture_span_addresser.sv =====
// Channel   Dir  Handshake                     Payload (low bit up)
// s_axis    in   s_axis_tvalid/s_axis_tready   span_x[15:0] span_y[31:16] span_count[38:32]
// m_axis    out  m_axis_tvalid/m_axis_tready   texel_x[15:0] texel_y[31:16], tlast=span_last
// cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data (always ready)
//
// Per span: accept, then four products on the single 32x18 multiplier, then span_count
// pixels at one texel word per cycle while the output register is not stalled. Repeat
// and mirror add setup on the bit-serial modulo unit, which reduces start point and step
// into the tile.
// Synchronous active-low reset loads the identity matrix, clamp, 1x1 texture.
// The span port is ready only in idle; the output register stalls pixel stepping.
module affine_texture_span_addresser
    import atsa_pkg::*;
#(
    parameter int MAX_SPAN   = 64,
    parameter int FRAC_BITS  = 16,
    parameter int COORD_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // span requests
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // span_x, span_y, span_count
    // texel addresses
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // texel_x, texel_y
    output logic             m_axis_tlast,   // span_last
    // register writes
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int SH  = FRAC_BITS + 1;            // doubled units carry one extra bit
    localparam int IW  = ACC_W - SH;               // integer coordinate width
    localparam int CB  = COORD_BITS;
    localparam int PW  = CB + 1;                   // tile period, up to twice the size
    localparam int KW  = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

    // configuration registers
    logic [CFG_W-1:0] r_inv_xx, r_inv_xy, r_inv_xt;
    logic [CFG_W-1:0] r_inv_yx, r_inv_yy, r_inv_yt;
    logic [1:0]       r_tile_mode;
    logic [CFG_W-1:0] r_tex_size;

    t_state r_state, n_state;

    logic signed [ACC_W-1:0]  r_ax, n_ax, r_ay, n_ay;   // source coords, doubled units
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic [2:0]               r_mi, n_mi;               // product index
    logic [1:0]               r_job, n_job;             // modulo job: bit1 y, bit0 step
    logic [MUL_B_W-2:0]       r_cx2, n_cx2, r_cy2, n_cy2;
    logic [KW-1:0]            r_k, n_k, r_last_k, n_last_k;
    logic [PW-1:0]            r_rx, n_rx, r_ry, n_ry;   // coord residues
    logic [PW-1:0]            r_dqx, n_dqx, r_dqy, n_dqy; // step residues
    logic                     r_ovalid, n_ovalid;
    logic [CB-1:0]            r_tx, n_tx, r_ty, n_ty;
    logic                     r_tlast, n_tlast;

    // derived values
    logic [CB-1:0]            w_w, w_h;
    logic [PW-1:0]            w_px, w_py;
    logic                     w_wrap;
    logic signed [ACC_W-1:0]  w_sx, w_sy;
    logic [SH:0]              w_fx, w_fy;
    logic signed [CFG_W-1:0]  w_ma;
    logic signed [MUL_B_W-1:0] w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic [CNT_W-1:0]         w_cnt;
    logic                     w_fire;

    // modulo unit hookup
    logic          w_mod_start;
    logic          w_mod_done;
    logic [IW-1:0] w_mod_val;
    logic [PW-1:0] w_mod_div;
    logic [PW-1:0] w_mod_rem;

    // ---------------- register writes ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_xx    <= CFG_W'(65536);
            r_inv_xy    <= '0;
            r_inv_xt    <= '0;
            r_inv_yx    <= '0;
            r_inv_yy    <= CFG_W'(65536);
            r_inv_yt    <= '0;
            r_tile_mode <= TILE_CLAMP;
            r_tex_size  <= CFG_W'(65537);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INV_XX:    r_inv_xx    <= i_cfg_data;
                CFG_INV_XY:    r_inv_xy    <= i_cfg_data;
                CFG_INV_XT:    r_inv_xt    <= i_cfg_data;
                CFG_INV_YX:    r_inv_yx    <= i_cfg_data;
                CFG_INV_YY:    r_inv_yy    <= i_cfg_data;
                CFG_INV_YT:    r_inv_yt    <= i_cfg_data;
                CFG_TILE_MODE: r_tile_mode <= i_cfg_data[1:0];
                CFG_TEX_SIZE:  r_tex_size  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // texture size, zero treated as one
    assign w_w = (r_tex_size[CB-1:0] == '0) ? CB'(1) : r_tex_size[CB-1:0];
    assign w_h = (r_tex_size[16+CB-1:16] == '0) ? CB'(1) : r_tex_size[16+CB-1:16];

    // wrap period: n for repeat, 2n for mirror
    assign w_wrap = (r_tile_mode == TILE_REPEAT) || (r_tile_mode == TILE_MIRROR);
    assign w_px = (r_tile_mode == TILE_MIRROR) ? {w_w, 1'b0} : {1'b0, w_w};
    assign w_py = (r_tile_mode == TILE_MIRROR) ? {w_h, 1'b0} : {1'b0, w_h};

    // per-pixel step = 2 * first matrix column
    assign w_sx = {{(ACC_W-CFG_W-1){r_inv_xx[CFG_W-1]}}, r_inv_xx, 1'b0};
    assign w_sy = {{(ACC_W-CFG_W-1){r_inv_yx[CFG_W-1]}}, r_inv_yx, 1'b0};

    // fraction carry into the integer part on a step
    assign w_fx = {1'b0, r_ax[SH-1:0]} + {1'b0, w_sx[SH-1:0]};
    assign w_fy = {1'b0, r_ay[SH-1:0]} + {1'b0, w_sy[SH-1:0]};

    // shared multiplier: xx*cx2, xy*cy2, yx*cx2, yy*cy2
    always_comb begin
        case (r_mi[1:0])
            2'd0:    w_ma = r_inv_xx;
            2'd1:    w_ma = r_inv_xy;
            2'd2:    w_ma = r_inv_yx;
            default: w_ma = r_inv_yy;
        endcase
        w_mb = r_mi[0] ? {1'b0, r_cy2} : {1'b0, r_cx2};
    end
    assign w_prod = w_ma * w_mb;

    // modulo jobs: start x, step x, start y, step y
    always_comb begin
        case (r_job)
            2'd0:    w_mod_val = r_ax[ACC_W-1:SH];
            2'd1:    w_mod_val = w_sx[ACC_W-1:SH];
            2'd2:    w_mod_val = r_ay[ACC_W-1:SH];
            default: w_mod_val = w_sy[ACC_W-1:SH];
        endcase
        w_mod_div = r_job[1] ? w_py : w_px;
    end
    assign w_mod_start = (r_state == S_MOD_GO);

    atsa_mod #(
        .DW (IW),
        .PW (PW)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mod_start),
        .i_value   (w_mod_val),
        .i_divisor (w_mod_div),
        .o_done    (w_mod_done),
        .o_rem     (w_mod_rem)
    );

    // tile rule for one axis
    function automatic logic [CB-1:0] f_tile(
        input logic [IW-1:0] i_int,
        input logic [PW-1:0] i_res,
        input logic [CB-1:0] i_n,
        input logic [1:0]    i_mode
    );
        logic [PW-1:0] v_refl;
        logic [CB-1:0] v_out;
        v_refl = {i_n, 1'b0} - PW'(1) - i_res;
        case (i_mode)
            TILE_REPEAT: v_out = i_res[CB-1:0];
            TILE_MIRROR: v_out = (i_res >= {1'b0, i_n}) ? v_refl[CB-1:0] : i_res[CB-1:0];
            default: begin
                if (i_int[IW-1]) begin
                    v_out = '0;
                end else if (i_int >= IW'(i_n)) begin
                    v_out = i_n - CB'(1);
                end else begin
                    v_out = i_int[CB-1:0];
                end
            end
        endcase
        return v_out;
    endfunction

    // residue advance: r + dq + carry, at most one period over
    function automatic logic [PW-1:0] f_adv(
        input logic [PW-1:0] i_res,
        input logic [PW-1:0] i_dq,
        input logic          i_cy,
        input logic [PW-1:0] i_p
    );
        logic [PW:0] v_sum;
        logic [PW:0] v_red;
        v_sum = {1'b0, i_res} + {1'b0, i_dq} + {{PW{1'b0}}, i_cy};
        v_red = v_sum - {1'b0, i_p};
        return (v_sum >= {1'b0, i_p}) ? v_red[PW-1:0] : v_sum[PW-1:0];
    endfunction

    // span count, saturated
    assign w_cnt = (s_axis_tdata[38:32] > CNT_W'(MAX_SPAN)) ? CNT_W'(MAX_SPAN)
                                                            : s_axis_tdata[38:32];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_fire = !r_ovalid || m_axis_tready;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state  = r_state;
        n_ax     = r_ax;
        n_ay     = r_ay;
        n_prod   = r_prod;
        n_mi     = r_mi;
        n_job    = r_job;
        n_cx2    = r_cx2;
        n_cy2    = r_cy2;
        n_k      = r_k;
        n_last_k = r_last_k;
        n_rx     = r_rx;
        n_ry     = r_ry;
        n_dqx    = r_dqx;
        n_dqy    = r_dqy;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_tx     = r_tx;
        n_ty     = r_ty;
        n_tlast  = r_tlast;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    // pixel centre in doubled units: 2p+1; start from 2*translation
                    n_cx2    = {s_axis_tdata[15:0], 1'b1};
                    n_cy2    = {s_axis_tdata[31:16], 1'b1};
                    n_ax     = {{(ACC_W-CFG_W-1){r_inv_xt[CFG_W-1]}}, r_inv_xt, 1'b0};
                    n_ay     = {{(ACC_W-CFG_W-1){r_inv_yt[CFG_W-1]}}, r_inv_yt, 1'b0};
                    n_mi     = '0;
                    n_k      = '0;
                    n_last_k = KW'(w_cnt - CNT_W'(1));
                    // zero-length span yields nothing
                    n_state  = (w_cnt == '0) ? S_IDLE : S_MUL;
                end
            end

            S_MUL: begin
                // product issued this cycle, previous one accumulated
                n_prod = w_prod;
                if (r_mi == 3'd1 || r_mi == 3'd2) begin
                    n_ax = r_ax + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                end else if (r_mi == 3'd3 || r_mi == 3'd4) begin
                    n_ay = r_ay + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                end
                n_mi = r_mi + 3'd1;
                if (r_mi == 3'd4) begin
                    n_job   = 2'd0;
                    n_state = w_wrap ? S_MOD_GO : S_EMIT;
                end
            end

            S_MOD_GO: begin
                n_state = S_MOD_WAIT;
            end

            S_MOD_WAIT: begin
                if (w_mod_done) begin
                    case (r_job)
                        2'd0:    n_rx  = w_mod_rem;
                        2'd1:    n_dqx = w_mod_rem;
                        2'd2:    n_ry  = w_mod_rem;
                        default: n_dqy = w_mod_rem;
                    endcase
                    n_job   = r_job + 2'd1;
                    n_state = (r_job == 2'd3) ? S_EMIT : S_MOD_GO;
                end
            end

            S_EMIT: begin
                if (w_fire) begin
                    n_ovalid = 1'b1;
                    n_tx     = f_tile(r_ax[ACC_W-1:SH], r_rx, w_w, r_tile_mode);
                    n_ty     = f_tile(r_ay[ACC_W-1:SH], r_ry, w_h, r_tile_mode);
                    n_tlast  = (r_k == r_last_k);
                    n_ax     = r_ax + w_sx;
                    n_ay     = r_ay + w_sy;
                    n_rx     = f_adv(r_rx, r_dqx, w_fx[SH], w_px);
                    n_ry     = f_adv(r_ry, r_dqy, w_fy[SH], w_py);
                    n_k      = r_k + KW'(1);
                    if (r_k == r_last_k) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax     <= n_ax;
        r_ay     <= n_ay;
        r_prod   <= n_prod;
        r_mi     <= n_mi;
        r_job    <= n_job;
        r_cx2    <= n_cx2;
        r_cy2    <= n_cy2;
        r_k      <= n_k;
        r_last_k <= n_last_k;
        r_rx     <= n_rx;
        r_ry     <= n_ry;
        r_dqx    <= n_dqx;
        r_dqy    <= n_dqy;
        r_tx     <= n_tx;
        r_ty     <= n_ty;
        r_tlast  <= n_tlast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {16'(r_ty), 16'(r_tx)};
    assign m_axis_tlast  = r_tlast;

endmodule
